// ===== sv/pto_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the price-time order matcher.
// No dependencies; imported by pto_front, pto_engine and the top level.
package pto_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  localparam logic [2:0] RES_RESTED    = 3'd0;
  localparam logic [2:0] RES_FILLED    = 3'd1;
  localparam logic [2:0] RES_DISCARDED = 3'd2;
  localparam logic [2:0] RES_POOL_FULL = 3'd3;
  localparam logic [2:0] RES_CANCELLED = 3'd4;
  localparam logic [2:0] RES_NOT_FOUND = 3'd5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  // classified command handed from the front to the engine
  typedef struct packed {
    logic        is_cancel;
    logic        id_ok;
    logic [11:0] id;
    logic [9:0]  slot;
    logic [23:0] qty;
    logic        buy;
    logic        market;
    logic        ioc;
  } cmd_t;

endpackage

// ===== sv/pto_front.sv =====
`timescale 1ns / 1ps
// Input side: accepts transactions, unpacks and classifies them, and
// buffers them in a two-entry queue for the engine. Depends on pto_pkg.
module pto_front #(
  parameter int PRICE_SLOTS = 1024,
  parameter int ID_SPACE    = 4096,
  parameter int VOLUME_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         enable_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [pto_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [0:0]                   s_axis_tuser_i,
  output pto_pkg::cmd_t                cmd_o,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i
);
  import pto_pkg::*;

  localparam logic [23:0] QMASK =
    (VOLUME_BITS >= 24) ? 24'hFFFFFF : 24'((64'd1 << VOLUME_BITS) - 64'd1);

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push, pop;
  logic [9:0] raw_slot;

  always_comb begin
    raw_slot         = s_axis_tdata_i[21:12];
    cmd_in.is_cancel = (s_axis_tuser_i[0] == OP_CANCEL);
    cmd_in.id        = s_axis_tdata_i[11:0];
    cmd_in.id_ok     = (32'(s_axis_tdata_i[11:0]) < ID_SPACE);
    cmd_in.slot      = (32'(raw_slot) >= PRICE_SLOTS) ? 10'(PRICE_SLOTS - 1) : raw_slot;
    cmd_in.qty       = s_axis_tdata_i[45:22] & QMASK;
    cmd_in.buy       = s_axis_tdata_i[46];
    cmd_in.market    = s_axis_tdata_i[47];
    cmd_in.ioc       = s_axis_tdata_i[48];
  end

  assign s_axis_tready_o = enable_i && (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o     = (cnt_q != 2'd0);
  assign pop             = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/pto_engine.sv =====
`timescale 1ns / 1ps
// Back end: order book memories and the sequencer that matches, rests and
// cancels orders, plus the result register. Depends on pto_pkg.
module pto_engine #(
  parameter int PRICE_SLOTS  = 1024,
  parameter int POOL_ENTRIES = 4096,
  parameter int ID_SPACE     = 4096,
  parameter int VOLUME_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  output logic                          ready_o,
  input  pto_pkg::cmd_t                 cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [pto_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [2:0]                    m_axis_tuser_o
);
  import pto_pkg::*;

  localparam int SW    = $clog2(PRICE_SLOTS);
  localparam int LW    = $clog2(2 * PRICE_SLOTS);
  localparam int EW    = $clog2(POOL_ENTRIES);
  localparam int CW    = $clog2(POOL_ENTRIES + 1);
  localparam int DW    = $clog2(ID_SPACE);
  localparam int VB    = VOLUME_BITS;
  localparam int NLVL  = 2 * PRICE_SLOTS;
  localparam int CLR_A = (ID_SPACE > NLVL) ? ID_SPACE : NLVL;
  localparam int CLR_N = (CLR_A > POOL_ENTRIES) ? CLR_A : POOL_ENTRIES;
  localparam int CLRW  = $clog2(CLR_N);

  typedef struct packed {
    logic          hv;
    logic [EW-1:0] head;
    logic [EW-1:0] tail;
    logic [35:0]   total;
  } lvl_t;

  typedef struct packed {
    logic          vld;
    logic [EW-1:0] ptr;
  } lnk_t;

  typedef struct packed {
    logic [LW-1:0] lvl;
    logic [11:0]   owner;
  } info_t;

  typedef struct packed {
    logic          vld;
    logic [EW-1:0] ent;
  } dir_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_M_CHK, ST_M_LVL, ST_M_ENT, ST_M_DIR,
    ST_M_WB, ST_SCAN, ST_RESOLVE, ST_R_LINK, ST_R_TAIL, ST_C_DIR, ST_C_ENT,
    ST_C_LVL, ST_RESP
  } state_e;

  // memories
  dir_t          dir_mem  [ID_SPACE];
  lvl_t          lvl_mem  [NLVL];
  lnk_t          next_mem [POOL_ENTRIES];
  lnk_t          prev_mem [POOL_ENTRIES];
  logic [VB-1:0] vol_mem  [POOL_ENTRIES];
  info_t         info_mem [POOL_ENTRIES];
  logic [EW-1:0] free_mem [POOL_ENTRIES];

  logic          dir_we, lvl_we, next_we, prev_we, vol_we, info_we, free_we;
  logic [DW-1:0] dir_wa, dir_ra;
  logic [LW-1:0] lvl_wa, lvl_ra;
  logic [EW-1:0] next_wa, prev_wa, ent_wa, ent_ra, free_wa, free_ra;
  dir_t          dir_wd, dir_rd;
  lvl_t          lvl_wd, lvl_rd;
  lnk_t          next_wd, prev_wd, next_rd, prev_rd;
  logic [VB-1:0] vol_wd, vol_rd;
  info_t         info_wd, info_rd;
  logic [EW-1:0] free_wd, free_rd;

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_rd <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_rd <= lvl_mem[lvl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vol_we) vol_mem[ent_wa] <= vol_wd;
    vol_rd <= vol_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (info_we) info_mem[ent_wa] <= info_wd;
    info_rd <= info_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_ra];
  end

  // control and working registers
  state_e          state_q, state_d;
  logic [CLRW-1:0] clr_q, clr_d;
  cmd_t            cmd_q, cmd_d;
  logic [VB-1:0]   rem_q, rem_d;
  logic            bid_vld_q, bid_vld_d, ask_vld_q, ask_vld_d;
  logic [SW-1:0]   bid_q, bid_d, ask_q, ask_d;
  logic [CW-1:0]   free_cnt_q, free_cnt_d;
  lvl_t            cur_q, cur_d;
  logic [LW-1:0]   lv_q, lv_d;
  logic [EW-1:0]   ent_q, ent_d;
  logic [11:0]     own_q, own_d;
  logic            own_ok_q, own_ok_d;
  lnk_t            c_next_q, c_next_d, c_prev_q, c_prev_d;
  logic [VB-1:0]   c_vol_q, c_vol_d;
  logic [SW-1:0]   scan_q, scan_d;
  logic            scan_ask_q, scan_ask_d;
  logic [2:0]      status_q, status_d;
  logic [23:0]     rested_q, rested_d;
  logic            out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [2:0]      out_user_q, out_user_d;

  always_comb begin
    logic          opp_vld;
    logic [SW-1:0] opp, slot, sv, nxt;
    logic [VB-1:0] m, nvol;
    logic [35:0]   m36;
    logic [36:0]   tsum;
    lvl_t          l;
    logic [23:0]   filled;

    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    rem_d      = rem_q;
    bid_vld_d  = bid_vld_q;
    bid_d      = bid_q;
    ask_vld_d  = ask_vld_q;
    ask_d      = ask_q;
    free_cnt_d = free_cnt_q;
    cur_d      = cur_q;
    lv_d       = lv_q;
    ent_d      = ent_q;
    own_d      = own_q;
    own_ok_d   = own_ok_q;
    c_next_d   = c_next_q;
    c_prev_d   = c_prev_q;
    c_vol_d    = c_vol_q;
    scan_d     = scan_q;
    scan_ask_d = scan_ask_q;
    status_d   = status_q;
    rested_d   = rested_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    out_user_d = out_user_q;

    dir_we  = 1'b0; dir_wa  = '0; dir_wd  = '0; dir_ra = DW'(cmd_q.id);
    lvl_we  = 1'b0; lvl_wa  = lv_q; lvl_wd = cur_q; lvl_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    vol_we  = 1'b0; info_we = 1'b0; ent_wa = ent_q; ent_ra = '0;
    vol_wd  = rem_q; info_wd = '0;
    free_we = 1'b0; free_wa = EW'(free_cnt_q); free_wd = ent_q; free_ra = '0;
    cmd_ready_o = 1'b0;

    opp_vld = cmd_q.buy ? ask_vld_q : bid_vld_q;
    opp     = cmd_q.buy ? ask_q : bid_q;
    slot    = SW'(cmd_q.slot);
    m       = (rem_q < vol_rd) ? rem_q : vol_rd;
    nvol    = vol_rd - m;
    m36     = 36'(m);
    tsum    = {1'b0, lvl_rd.total} + 37'(rem_q);
    l       = lvl_rd;
    sv      = (lv_q >= LW'(PRICE_SLOTS)) ? SW'(lv_q - LW'(PRICE_SLOTS)) : SW'(lv_q);
    nxt     = scan_ask_q ? scan_q + SW'(1) : scan_q - SW'(1);
    filled  = 24'(VB'(cmd_q.qty) - rem_q);

    unique case (state_q)
      ST_CLEAR: begin
        if (int'(clr_q) < ID_SPACE) begin
          dir_we = 1'b1;
          dir_wa = DW'(clr_q);
        end
        if (int'(clr_q) < NLVL) begin
          lvl_we = 1'b1;
          lvl_wa = LW'(clr_q);
          lvl_wd = '0;
        end
        if (int'(clr_q) < POOL_ENTRIES) begin
          free_we = 1'b1;
          free_wa = EW'(clr_q);
          free_wd = EW'(clr_q);
        end
        clr_d = clr_q + CLRW'(1);
        if (clr_q == CLRW'(CLR_N - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          rem_d    = VB'(cmd_i.qty);
          rested_d = '0;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        if (cmd_q.is_cancel) begin
          if (!cmd_q.id_ok) begin
            status_d = RES_NOT_FOUND;
            state_d  = ST_RESP;
          end else begin
            state_d = ST_C_DIR;
          end
        end else begin
          state_d = ST_M_CHK;
        end
      end
      ST_M_CHK: begin
        if (rem_q == '0 || !opp_vld) begin
          state_d = ST_RESOLVE;
        end else if (!cmd_q.market && (cmd_q.buy ? (slot < opp) : (slot > opp))) begin
          state_d = ST_RESOLVE;
        end else begin
          lv_d    = cmd_q.buy ? LW'(PRICE_SLOTS) + LW'(opp) : LW'(opp);
          lvl_ra  = lv_d;
          state_d = ST_M_LVL;
        end
      end
      ST_M_LVL: begin
        cur_d = lvl_rd;
        if (!lvl_rd.hv) begin
          state_d = ST_M_WB;
        end else begin
          ent_ra  = lvl_rd.head;
          ent_d   = lvl_rd.head;
          state_d = ST_M_ENT;
        end
      end
      ST_M_ENT: begin
        rem_d       = rem_q - m;
        cur_d.total = (cur_q.total > m36) ? cur_q.total - m36 : '0;
        if (nvol != '0) begin
          vol_we  = 1'b1;
          vol_wd  = nvol;
          state_d = ST_M_WB;
        end else begin
          if (next_rd.vld) begin
            cur_d.head = next_rd.ptr;
            prev_we    = 1'b1;
            prev_wa    = next_rd.ptr;
            prev_wd    = '0;
          end else begin
            cur_d.hv = 1'b0;
          end
          if (free_cnt_q < CW'(POOL_ENTRIES)) begin
            free_we    = 1'b1;
            free_cnt_d = free_cnt_q + CW'(1);
          end
          own_d    = info_rd.owner;
          own_ok_d = (32'(info_rd.owner) < ID_SPACE);
          dir_ra   = DW'(info_rd.owner);
          state_d  = ST_M_DIR;
        end
      end
      ST_M_DIR: begin
        if (own_ok_q && dir_rd.vld && dir_rd.ent == ent_q) begin
          dir_we = 1'b1;
          dir_wa = DW'(own_q);
          dir_wd = '0;
        end
        if (cur_q.hv && rem_q != '0) begin
          ent_ra  = cur_q.head;
          ent_d   = cur_q.head;
          state_d = ST_M_ENT;
        end else begin
          state_d = ST_M_WB;
        end
      end
      ST_M_WB: begin
        lvl_we = 1'b1;
        state_d = ST_M_CHK;
        if (!cur_q.hv) begin
          lvl_wd.total = '0;
          scan_ask_d   = cmd_q.buy;
          if (cmd_q.buy) begin
            if (ask_q == SW'(PRICE_SLOTS - 1)) begin
              ask_vld_d = 1'b0;
            end else begin
              scan_d  = ask_q + SW'(1);
              lvl_ra  = LW'(PRICE_SLOTS) + LW'(scan_d);
              state_d = ST_SCAN;
            end
          end else begin
            if (bid_q == '0) begin
              bid_vld_d = 1'b0;
            end else begin
              scan_d  = bid_q - SW'(1);
              lvl_ra  = LW'(scan_d);
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (lvl_rd.hv || (scan_ask_q ? (scan_q == SW'(PRICE_SLOTS - 1)) : (scan_q == '0))) begin
          if (scan_ask_q) begin
            ask_vld_d = lvl_rd.hv;
            ask_d     = scan_q;
          end else begin
            bid_vld_d = lvl_rd.hv;
            bid_d     = scan_q;
          end
          state_d = cmd_q.is_cancel ? ST_RESP : ST_M_CHK;
        end else begin
          scan_d = nxt;
          lvl_ra = scan_ask_q ? LW'(PRICE_SLOTS) + LW'(nxt) : LW'(nxt);
        end
      end
      ST_RESOLVE: begin
        if (rem_q == '0) begin
          status_d = RES_FILLED;
          state_d  = ST_RESP;
        end else if (cmd_q.market || cmd_q.ioc || !cmd_q.id_ok) begin
          status_d = RES_DISCARDED;
          state_d  = ST_RESP;
        end else if (free_cnt_q == '0) begin
          status_d = RES_POOL_FULL;
          state_d  = ST_RESP;
        end else begin
          free_cnt_d = free_cnt_q - CW'(1);
          free_ra    = EW'(free_cnt_d);
          lv_d       = cmd_q.buy ? LW'(slot) : LW'(PRICE_SLOTS) + LW'(slot);
          lvl_ra     = lv_d;
          state_d    = ST_R_LINK;
        end
      end
      ST_R_LINK: begin
        cur_d   = lvl_rd;
        ent_d   = free_rd;
        ent_wa  = free_rd;
        vol_we  = 1'b1;
        info_we = 1'b1;
        info_wd = '{lvl: lv_q, owner: cmd_q.id};
        next_we = 1'b1;
        next_wa = free_rd;
        next_wd = '0;
        prev_we = 1'b1;
        prev_wa = free_rd;
        if (lvl_rd.hv) begin
          prev_wd = '{vld: 1'b1, ptr: lvl_rd.tail};
          state_d = ST_R_TAIL;
        end else begin
          prev_wd = '0;
          l.hv    = 1'b1;
          l.head  = free_rd;
          state_d = ST_RESP;
        end
        l.tail  = free_rd;
        l.total = tsum[36] ? '1 : tsum[35:0];
        lvl_we  = 1'b1;
        lvl_wd  = l;
        dir_we  = 1'b1;
        dir_wa  = DW'(cmd_q.id);
        dir_wd  = '{vld: 1'b1, ent: free_rd};
        if (cmd_q.buy) begin
          if (!bid_vld_q || slot > bid_q) begin
            bid_vld_d = 1'b1;
            bid_d     = slot;
          end
        end else begin
          if (!ask_vld_q || slot < ask_q) begin
            ask_vld_d = 1'b1;
            ask_d     = slot;
          end
        end
        status_d = RES_RESTED;
        rested_d = 24'(rem_q);
      end
      ST_R_TAIL: begin
        next_we = 1'b1;
        next_wa = cur_q.tail;
        next_wd = '{vld: 1'b1, ptr: ent_q};
        state_d = ST_RESP;
      end
      ST_C_DIR: begin
        if (!dir_rd.vld) begin
          status_d = RES_NOT_FOUND;
          state_d  = ST_RESP;
        end else begin
          ent_d   = dir_rd.ent;
          ent_ra  = dir_rd.ent;
          state_d = ST_C_ENT;
        end
      end
      ST_C_ENT: begin
        c_next_d = next_rd;
        c_prev_d = prev_rd;
        c_vol_d  = vol_rd;
        lv_d     = info_rd.lvl;
        lvl_ra   = info_rd.lvl;
        state_d  = ST_C_LVL;
      end
      ST_C_LVL: begin
        if (c_prev_q.vld) begin
          next_we = 1'b1;
          next_wa = c_prev_q.ptr;
          next_wd = c_next_q;
        end else if (c_next_q.vld) begin
          l.head = c_next_q.ptr;
        end else begin
          l.hv = 1'b0;
        end
        if (c_next_q.vld) begin
          prev_we = 1'b1;
          prev_wa = c_next_q.ptr;
          prev_wd = c_prev_q;
        end else if (c_prev_q.vld) begin
          l.tail = c_prev_q.ptr;
        end
        l.total  = (lvl_rd.total > 36'(c_vol_q)) ? lvl_rd.total - 36'(c_vol_q) : '0;
        rested_d = 24'(c_vol_q);
        dir_we   = 1'b1;
        dir_wa   = DW'(cmd_q.id);
        dir_wd   = '0;
        if (free_cnt_q < CW'(POOL_ENTRIES)) begin
          free_we    = 1'b1;
          free_cnt_d = free_cnt_q + CW'(1);
        end
        status_d = RES_CANCELLED;
        state_d  = ST_RESP;
        if (!l.hv) begin
          l.total = '0;
          if (lv_q < LW'(PRICE_SLOTS)) begin
            if (bid_vld_q && sv == bid_q) begin
              if (sv == '0) begin
                bid_vld_d = 1'b0;
              end else begin
                scan_ask_d = 1'b0;
                scan_d     = sv - SW'(1);
                lvl_ra     = LW'(scan_d);
                state_d    = ST_SCAN;
              end
            end
          end else begin
            if (ask_vld_q && sv == ask_q) begin
              if (sv == SW'(PRICE_SLOTS - 1)) begin
                ask_vld_d = 1'b0;
              end else begin
                scan_ask_d = 1'b1;
                scan_d     = sv + SW'(1);
                lvl_ra     = LW'(PRICE_SLOTS) + LW'(scan_d);
                state_d    = ST_SCAN;
              end
            end
          end
        end
        lvl_we = 1'b1;
        lvl_wd = l;
      end
      ST_RESP: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_user_d = status_q;
          out_data_d = {2'b00,
                        (ask_vld_q ? 10'(ask_q) : 10'd0), ask_vld_q,
                        (bid_vld_q ? 10'(bid_q) : 10'd0), bid_vld_q,
                        rested_q, filled};
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      bid_vld_q  <= 1'b0;
      ask_vld_q  <= 1'b0;
      free_cnt_q <= CW'(POOL_ENTRIES);
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      bid_vld_q  <= bid_vld_d;
      ask_vld_q  <= ask_vld_d;
      free_cnt_q <= free_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rem_q      <= rem_d;
    bid_q      <= bid_d;
    ask_q      <= ask_d;
    cur_q      <= cur_d;
    lv_q       <= lv_d;
    ent_q      <= ent_d;
    own_q      <= own_d;
    own_ok_q   <= own_ok_d;
    c_next_q   <= c_next_d;
    c_prev_q   <= c_prev_d;
    c_vol_q    <= c_vol_d;
    scan_q     <= scan_d;
    scan_ask_q <= scan_ask_d;
    status_q   <= status_d;
    rested_q   <= rested_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign ready_o         = (state_q != ST_CLEAR);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CW'(POOL_ENTRIES))
    else $error("free count above pool size");

  a_uncrossed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && bid_vld_q && ask_vld_q) |-> (bid_q < ask_q))
    else $error("book crossed between orders");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_RESP))
    else $error("result raised outside response state");

endmodule

// ===== sv/price_time_order_matcher.sv =====
`timescale 1ns / 1ps
// Top level of the price-time order matcher: front end, command queue and
// matching engine. Depends on pto_pkg, pto_front and pto_engine.
//
// Usage:
//   s_axis carries one order transaction: tuser[0] is the opcode (add or
//   cancel), tdata holds the order fields. m_axis returns one result per
//   order: tuser holds the status, tdata the fill and rest volumes and the
//   best bid and ask after the order.
//   The time an add takes depends on the price levels it visits, the
//   resting orders it consumes and the price slots walked when a level
//   empties; the time of a cancel depends on the same scan. The
//   data-dependent part comes from the level scan, which reads one price
//   level per cycle from the level memory. The engine works on one order
//   at a time.
//   After reset a clearing pass initializes the directory, levels and free
//   list; s_axis_tready stays low until it ends.
//   A two-entry queue lets the front accept orders while the engine works,
//   and the result register holds a result while m_axis is stalled; the
//   engine then waits before delivering the next one.
module price_time_order_matcher #(
  parameter int PRICE_SLOTS  = 1024,
  parameter int POOL_ENTRIES = 4096,
  parameter int ID_SPACE     = 4096,
  parameter int VOLUME_BITS  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // order_id[11:0], price_slot[21:12], quantity[45:22], buy_side[46],
  // market_flag[47], ioc_flag[48], zero fill above
  input  logic [pto_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode[0]
  input  logic [0:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // filled_quantity[23:0], rested_quantity[47:24], bid_present[48],
  // best_bid_slot[58:49], ask_present[59], best_ask_slot[69:60], zero fill
  output logic [pto_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]                     m_axis_tuser_o
);
  import pto_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready, eng_ready;

  pto_front #(
    .PRICE_SLOTS (PRICE_SLOTS),
    .ID_SPACE    (ID_SPACE),
    .VOLUME_BITS (VOLUME_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .enable_i        (eng_ready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready)
  );

  pto_engine #(
    .PRICE_SLOTS  (PRICE_SLOTS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .ID_SPACE     (ID_SPACE),
    .VOLUME_BITS  (VOLUME_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ready_o         (eng_ready),
    .cmd_i           (cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
